FILE: rtl/look_at_view_matrix_macros.svh
// assertion macros for the look-at view matrix checker
// expects clk and rst in the scope where a macro is used
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LAVM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define LAVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/lavm_pkg.sv
// shared widths, types and fixed-point helpers of the look-at view matrix
// no dependencies
`default_nettype none

package lavm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int D_W       = DATA_W + 1;
  localparam int NORM_TOP  = 29;
  localparam int NM_W      = NORM_TOP + 1;
  localparam int SQ_W      = 2 * NM_W + 2;
  localparam int SQ_STEPS  = NM_W + 1;
  localparam int LEN_W     = NM_W + 1;
  localparam int QB        = FRAC_BITS + 1;
  localparam int DIV_W     = NM_W + FRAC_BITS + 2;
  localparam int WQ_W      = FRAC_BITS + 2;
  localparam int PX_W      = DATA_W + WQ_W;
  localparam int MAG_W     = PX_W + 1;
  localparam int SH_W      = $clog2(MAG_W);
  localparam int ROW_W     = FRAC_BITS + 3;
  localparam int PW_W      = 2 * WQ_W;
  localparam int EP_W      = WQ_W + DATA_W;
  localparam int EV_W      = ROW_W + DATA_W;
  localparam int DOT_W     = EV_W + 2;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd3;
  localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -(64'sd1 <<< (DATA_W - 1));

  // data that rides along a normalize unit
  typedef struct packed {
    logic [2:0][DATA_W-1:0] eye;
    logic [2:0][DATA_W-1:0] up;
    logic [2:0][WQ_W-1:0]   w;
    logic                   degen;
  } side_t;

  // finished matrix: rows u, v, w and their translation terms
  typedef struct packed {
    logic [2:0][2:0][ROW_W-1:0] e;
    logic [2:0][DATA_W-1:0]     t;
    logic                       degen;
  } mat_t;

  // drop FRAC_BITS, round half away from zero
  function automatic logic signed [63:0] rnd_scale(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] m;
    mag = x[63] ? 64'(-x) : 64'(x);
    m = (mag + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [DATA_W-1:0] sat_data(input logic signed [63:0] x);
    logic [DATA_W-1:0] r;
    if (x > SAT_HI) r = SAT_HI[DATA_W-1:0];
    else if (x < SAT_LO) r = SAT_LO[DATA_W-1:0];
    else r = x[DATA_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lavm_norm.sv
// pipelined vector normalizer: leading-one scale, squares, digit-serial sqrt,
// bit-per-stage divide; uses lavm_pkg
`default_nettype none

module lavm_norm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [2:0][lavm_pkg::MAG_W-1:0]  in_mag,
  input  logic [2:0]                       in_neg,
  input  lavm_pkg::side_t                  in_side,
  output logic                             out_valid,
  output logic [2:0][lavm_pkg::WQ_W-1:0]   out_vec,
  output logic                             out_zero,
  output lavm_pkg::side_t                  out_side
);
  import lavm_pkg::*;

  typedef struct packed {
    logic [2:0][NM_W-1:0] m;
    logic [2:0]           neg;
    logic                 zero;
    side_t                side;
    logic [SQ_W-1:0]      x;
    logic [SQ_W-1:0]      r;
  } sq_t;

  typedef struct packed {
    logic [2:0][DIV_W-1:0] rem;
    logic [2:0][QB-1:0]    q;
    logic [LEN_W-1:0]      len;
    logic [2:0]            neg;
    logic                  zero;
    side_t                 side;
  } dv_t;

  // stage 0: leading one of the largest magnitude
  logic                  s0_valid;
  logic [2:0][MAG_W-1:0] s0_mag;
  logic [2:0]            s0_neg;
  logic                  s0_zero;
  logic [SH_W-1:0]       s0_top;
  side_t                 s0_side;
  logic [MAG_W-1:0]      any_bits;
  logic [SH_W-1:0]       top_c;

  always_comb begin
    any_bits = in_mag[0] | in_mag[1] | in_mag[2];
    top_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (any_bits[i]) top_c = SH_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else if (en) s0_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mag  <= in_mag;
      s0_neg  <= in_neg;
      s0_zero <= (any_bits == '0);
      s0_top  <= top_c;
      s0_side <= in_side;
    end
  end

  // stage 1: scale so the top set bit sits at NORM_TOP
  logic                 s1_valid;
  logic [2:0][NM_W-1:0] s1_m;
  logic [2:0]           s1_neg;
  logic                 s1_zero;
  side_t                s1_side;
  logic [2:0][NM_W-1:0] m_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s0_top > SH_W'(NORM_TOP)) m_c[i] = NM_W'(s0_mag[i] >> (s0_top - SH_W'(NORM_TOP)));
      else m_c[i] = NM_W'(s0_mag[i] << (SH_W'(NORM_TOP) - s0_top));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= s0_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m    <= m_c;
      s1_neg  <= s0_neg;
      s1_zero <= s0_zero;
      s1_side <= s0_side;
    end
  end

  // stage 2: squares
  logic                   s2_valid;
  logic [2:0][2*NM_W-1:0] s2_sq;
  logic [2:0][NM_W-1:0]   s2_m;
  logic [2:0]             s2_neg;
  logic                   s2_zero;
  side_t                  s2_side;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= (2*NM_W)'(s1_m[i]) * (2*NM_W)'(s1_m[i]);
      end
      s2_m    <= s1_m;
      s2_neg  <= s1_neg;
      s2_zero <= s1_zero;
      s2_side <= s1_side;
    end
  end

  // stage 3: sum of squares, then one root bit per stage
  sq_t  sqs    [SQ_STEPS+1];
  logic sq_vld [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (en) sq_vld[0] <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqs[0].m    <= s2_m;
      sqs[0].neg  <= s2_neg;
      sqs[0].zero <= s2_zero;
      sqs[0].side <= s2_side;
      sqs[0].x    <= SQ_W'(s2_sq[0]) + SQ_W'(s2_sq[1]) + SQ_W'(s2_sq[2]);
      sqs[0].r    <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    sq_t             nxt;
    logic [SQ_W-1:0] trial;

    always_comb begin
      nxt = sqs[k];
      trial = sqs[k].r + BIT;
      if (sqs[k].x >= trial) begin
        nxt.x = sqs[k].x - trial;
        nxt.r = (sqs[k].r >> 1) + BIT;
      end else begin
        nxt.r = sqs[k].r >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else if (en) sq_vld[k+1] <= sq_vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) sqs[k+1] <= nxt;
    end
  end

  // divide stages: rounded m * 2^FRAC_BITS / len, one quotient bit each
  dv_t              dvs    [QB+1];
  logic             dv_vld [QB+1];
  logic [LEN_W-1:0] len_c;

  assign len_c = sqs[SQ_STEPS].r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (en) dv_vld[0] <= sq_vld[SQ_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dvs[0].rem[i] <= (DIV_W'(sqs[SQ_STEPS].m[i]) << FRAC_BITS) + DIV_W'(len_c >> 1);
      end
      dvs[0].q    <= '0;
      dvs[0].len  <= len_c;
      dvs[0].neg  <= sqs[SQ_STEPS].neg;
      dvs[0].zero <= sqs[SQ_STEPS].zero;
      dvs[0].side <= sqs[SQ_STEPS].side;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    dv_t              nxt;
    logic [DIV_W-1:0] dsub;

    always_comb begin
      nxt = dvs[k];
      dsub = DIV_W'(dvs[k].len) << SH;
      for (int i = 0; i < 3; i++) begin
        if (dvs[k].rem[i] >= dsub) begin
          nxt.rem[i] = dvs[k].rem[i] - dsub;
          nxt.q[i][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_vld[k+1] <= 1'b0;
      else if (en) dv_vld[k+1] <= dv_vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) dvs[k+1] <= nxt;
    end
  end

  // output stage: restore signs, zero vector when degenerate
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_vld[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dvs[QB].zero) out_vec[i] <= '0;
        else if (dvs[QB].neg[i]) out_vec[i] <= -WQ_W'(dvs[QB].q[i]);
        else out_vec[i] <= WQ_W'(dvs[QB].q[i]);
      end
      out_zero <= dvs[QB].zero;
      out_side <= dvs[QB].side;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lavm_rows.sv
// row builder: v = w x u and the three translation terms, five stages
// uses lavm_pkg
`default_nettype none

module lavm_rows (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [2:0][lavm_pkg::WQ_W-1:0]   w,
  input  logic [2:0][lavm_pkg::WQ_W-1:0]   u,
  input  logic [2:0][lavm_pkg::DATA_W-1:0] eye,
  input  logic                             degen,
  output logic                             out_valid,
  output lavm_pkg::mat_t                   mat
);
  import lavm_pkg::*;

  // stage 0: cross and eye products
  logic                   r0_valid;
  logic [5:0][PW_W-1:0]   r0_pc;
  logic [2:0][EP_W-1:0]   r0_pu;
  logic [2:0][EP_W-1:0]   r0_pw;
  logic [2:0][WQ_W-1:0]   r0_u;
  logic [2:0][WQ_W-1:0]   r0_w;
  logic [2:0][DATA_W-1:0] r0_eye;
  logic                   r0_degen;
  logic [5:0][PW_W-1:0]   pc_c;
  logic [2:0][EP_W-1:0]   pu_c;
  logic [2:0][EP_W-1:0]   pw_c;

  for (genvar i = 0; i < 3; i++) begin : g_prod
    localparam int A = (i + 1) % 3;
    localparam int B = (i + 2) % 3;
    logic signed [PW_W-1:0] wa, wb, ua, ub;
    logic signed [EP_W-1:0] ue, we, ee;

    always_comb begin
      wa = PW_W'($signed(w[A]));
      wb = PW_W'($signed(w[B]));
      ua = PW_W'($signed(u[A]));
      ub = PW_W'($signed(u[B]));
      pc_c[2*i]   = wa * ub;
      pc_c[2*i+1] = wb * ua;
      ue = EP_W'($signed(u[i]));
      we = EP_W'($signed(w[i]));
      ee = EP_W'($signed(eye[i]));
      pu_c[i] = ue * ee;
      pw_c[i] = we * ee;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) r0_valid <= 1'b0;
    else if (en) r0_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_pc    <= pc_c;
      r0_pu    <= pu_c;
      r0_pw    <= pw_c;
      r0_u     <= u;
      r0_w     <= w;
      r0_eye   <= eye;
      r0_degen <= degen;
    end
  end

  // stage 1: v rounded, dot sums for u and w
  logic                   r1_valid;
  logic [2:0][ROW_W-1:0]  r1_v;
  logic [DOT_W-1:0]       r1_dotu;
  logic [DOT_W-1:0]       r1_dotw;
  logic [2:0][WQ_W-1:0]   r1_u;
  logic [2:0][WQ_W-1:0]   r1_w;
  logic [2:0][DATA_W-1:0] r1_eye;
  logic                   r1_degen;

  always_ff @(posedge clk) begin
    if (rst) r1_valid <= 1'b0;
    else if (en) r1_valid <= r0_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r1_v[i] <= ROW_W'(rnd_scale(64'($signed(r0_pc[2*i])) - 64'($signed(r0_pc[2*i+1]))));
      end
      r1_dotu  <= DOT_W'($signed(r0_pu[0])) + DOT_W'($signed(r0_pu[1]))
                + DOT_W'($signed(r0_pu[2]));
      r1_dotw  <= DOT_W'($signed(r0_pw[0])) + DOT_W'($signed(r0_pw[1]))
                + DOT_W'($signed(r0_pw[2]));
      r1_u     <= r0_u;
      r1_w     <= r0_w;
      r1_eye   <= r0_eye;
      r1_degen <= r0_degen;
    end
  end

  // stage 2: v times eye, translation for u and w
  logic                   r2_valid;
  logic [2:0][EV_W-1:0]   r2_pv;
  logic [DATA_W-1:0]      r2_tu;
  logic [DATA_W-1:0]      r2_tw;
  logic [2:0][ROW_W-1:0]  r2_v;
  logic [2:0][WQ_W-1:0]   r2_u;
  logic [2:0][WQ_W-1:0]   r2_w;
  logic                   r2_degen;
  logic [2:0][EV_W-1:0]   pv_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pv_c[i] = EV_W'($signed(EV_W'($signed(r1_v[i]))) * $signed(EV_W'($signed(r1_eye[i]))));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) r2_valid <= 1'b0;
    else if (en) r2_valid <= r1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_pv    <= pv_c;
      r2_tu    <= sat_data(-rnd_scale(64'($signed(r1_dotu))));
      r2_tw    <= sat_data(-rnd_scale(64'($signed(r1_dotw))));
      r2_v     <= r1_v;
      r2_u     <= r1_u;
      r2_w     <= r1_w;
      r2_degen <= r1_degen;
    end
  end

  // stage 3: dot sum for v
  logic                  r3_valid;
  logic [DOT_W-1:0]      r3_dotv;
  logic [DATA_W-1:0]     r3_tu;
  logic [DATA_W-1:0]     r3_tw;
  logic [2:0][ROW_W-1:0] r3_v;
  logic [2:0][WQ_W-1:0]  r3_u;
  logic [2:0][WQ_W-1:0]  r3_w;
  logic                  r3_degen;

  always_ff @(posedge clk) begin
    if (rst) r3_valid <= 1'b0;
    else if (en) r3_valid <= r2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_dotv  <= DOT_W'($signed(r2_pv[0])) + DOT_W'($signed(r2_pv[1]))
                + DOT_W'($signed(r2_pv[2]));
      r3_tu    <= r2_tu;
      r3_tw    <= r2_tw;
      r3_v     <= r2_v;
      r3_u     <= r2_u;
      r3_w     <= r2_w;
      r3_degen <= r2_degen;
    end
  end

  // stage 4: translation for v, assemble the matrix
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= r3_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mat.e[0][i] <= ROW_W'($signed(r3_u[i]));
        mat.e[1][i] <= r3_v[i];
        mat.e[2][i] <= ROW_W'($signed(r3_w[i]));
      end
      mat.t[0] <= r3_tu;
      mat.t[1] <= sat_data(-rnd_scale(64'($signed(r3_dotv))));
      mat.t[2] <= r3_tw;
      mat.degen <= r3_degen;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/look_at_view_matrix.sv
// Look-at view matrix. Each transfer on the input side carries one camera
// set-up (eye, target, up, signed fixed point with FRAC_BITS fraction bits,
// Q16.16 by default) and produces four transfers on the output side, rows 0
// to 3 of the view matrix in order: u, v and w in col0..col2 with
// col3 = -dot(row, eye) saturated to 32 bits, then 0, 0, 0, 1.0 with last
// set. degenerate is set on all four rows when eye equals target or up is
// parallel to the view direction; the affected vector is then zero. The
// work is a single stall-together pipeline: an input register, a normalize
// unit for w (four setup stages, one square-root bit per stage over 31
// stages, one divider setup stage, one quotient bit per stage over
// FRAC_BITS+1 stages, one output stage), two cross product stages, a second
// normalize unit for u and five stages that form v and the translation
// terms. Many set-ups are in flight at once; the sustained rate is set by
// the single row-wide output port, which needs four transfers per matrix,
// with the first row of the next matrix directly after the last row of the
// previous one. The last stage feeds a matrix holding register that is
// loaded while the previous matrix's final row transfers; the pipeline
// halts only while a finished matrix waits and that register cannot take it.
// Uses lavm_pkg, lavm_norm and lavm_rows.
`default_nettype none

module look_at_view_matrix (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lavm_pkg::DATA_W-1:0] eye_x,
  input  logic [lavm_pkg::DATA_W-1:0] eye_y,
  input  logic [lavm_pkg::DATA_W-1:0] eye_z,
  input  logic [lavm_pkg::DATA_W-1:0] target_x,
  input  logic [lavm_pkg::DATA_W-1:0] target_y,
  input  logic [lavm_pkg::DATA_W-1:0] target_z,
  input  logic [lavm_pkg::DATA_W-1:0] up_x,
  input  logic [lavm_pkg::DATA_W-1:0] up_y,
  input  logic [lavm_pkg::DATA_W-1:0] up_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  row_index,
  output logic [lavm_pkg::DATA_W-1:0] col0,
  output logic [lavm_pkg::DATA_W-1:0] col1,
  output logic [lavm_pkg::DATA_W-1:0] col2,
  output logic [lavm_pkg::DATA_W-1:0] col3,
  output logic                        degenerate,
  output logic                        last
);
  import lavm_pkg::*;

  // whole pipeline advances together; it only halts when a finished
  // matrix cannot move into the holding register
  logic en;
  logic rows_valid;
  mat_t rows_mat;
  logic full;
  logic [1:0] cnt;
  mat_t hold;
  logic take;
  logic load_ok;

  assign take    = full && out_ready;
  assign load_ok = !full || (take && (cnt == ROW_LAST));
  assign en      = !rows_valid || load_ok;
  assign in_ready = en;

  // input stage: eye - target as magnitude and sign
  logic [2:0][DATA_W-1:0] eye_v, tgt_v, up_v;
  logic                   a_valid;
  logic [2:0][MAG_W-1:0]  a_mag;
  logic [2:0]             a_neg;
  side_t                  a_side;
  logic [2:0][MAG_W-1:0]  dmag_c;
  logic [2:0]             dneg_c;

  assign eye_v = {eye_z, eye_y, eye_x};
  assign tgt_v = {target_z, target_y, target_x};
  assign up_v  = {up_z, up_y, up_x};

  always_comb begin
    logic signed [D_W-1:0] d;
    logic [D_W-1:0]        dm;
    for (int i = 0; i < 3; i++) begin
      d = D_W'($signed(eye_v[i])) - D_W'($signed(tgt_v[i]));
      dm = d[D_W-1] ? D_W'(-d) : D_W'(d);
      dmag_c[i] = MAG_W'(dm);
      dneg_c[i] = d[D_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag        <= dmag_c;
      a_neg        <= dneg_c;
      a_side.eye   <= eye_v;
      a_side.up    <= up_v;
      a_side.w     <= '0;
      a_side.degen <= 1'b0;
    end
  end

  // w = normalize(eye - target)
  logic                 n1_valid;
  logic [2:0][WQ_W-1:0] n1_vec;
  logic                 n1_zero;
  side_t                n1_side;

  lavm_norm u_norm_w (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (a_valid),
    .in_mag   (a_mag),
    .in_neg   (a_neg),
    .in_side  (a_side),
    .out_valid(n1_valid),
    .out_vec  (n1_vec),
    .out_zero (n1_zero),
    .out_side (n1_side)
  );

  // up x w at full precision: products, then differences
  logic                 x0_valid;
  logic [5:0][PX_W-1:0] x0_p;
  side_t                x0_side;
  logic [5:0][PX_W-1:0] px_c;

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int A = (i + 1) % 3;
    localparam int B = (i + 2) % 3;
    logic signed [PX_W-1:0] ua, ub, wa, wb;

    always_comb begin
      ua = PX_W'($signed(n1_side.up[A]));
      ub = PX_W'($signed(n1_side.up[B]));
      wa = PX_W'($signed(n1_vec[A]));
      wb = PX_W'($signed(n1_vec[B]));
      px_c[2*i]   = ua * wb;
      px_c[2*i+1] = ub * wa;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) x0_valid <= 1'b0;
    else if (en) x0_valid <= n1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_p          <= px_c;
      x0_side.eye   <= n1_side.eye;
      x0_side.up    <= n1_side.up;
      x0_side.w     <= n1_vec;
      x0_side.degen <= n1_zero;
    end
  end

  logic                  x1_valid;
  logic [2:0][MAG_W-1:0] x1_mag;
  logic [2:0]            x1_neg;
  side_t                 x1_side;
  logic [2:0][MAG_W-1:0] cmag_c;
  logic [2:0]            cneg_c;

  always_comb begin
    logic signed [MAG_W-1:0] c;
    for (int i = 0; i < 3; i++) begin
      c = MAG_W'($signed(x0_p[2*i])) - MAG_W'($signed(x0_p[2*i+1]));
      cmag_c[i] = c[MAG_W-1] ? MAG_W'(-c) : MAG_W'(c);
      cneg_c[i] = c[MAG_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) x1_valid <= 1'b0;
    else if (en) x1_valid <= x0_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_mag  <= cmag_c;
      x1_neg  <= cneg_c;
      x1_side <= x0_side;
    end
  end

  // u = normalize(up x w)
  logic                 n2_valid;
  logic [2:0][WQ_W-1:0] n2_vec;
  logic                 n2_zero;
  side_t                n2_side;

  lavm_norm u_norm_u (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (x1_valid),
    .in_mag   (x1_mag),
    .in_neg   (x1_neg),
    .in_side  (x1_side),
    .out_valid(n2_valid),
    .out_vec  (n2_vec),
    .out_zero (n2_zero),
    .out_side (n2_side)
  );

  // v and the translation column
  lavm_rows u_rows (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (n2_valid),
    .w        (n2_side.w),
    .u        (n2_vec),
    .eye      (n2_side.eye),
    .degen    (n2_side.degen | n2_zero),
    .out_valid(rows_valid),
    .mat      (rows_mat)
  );

  // matrix holding register, stepped out one row per output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      cnt  <= ROW_FIRST;
    end else if (rows_valid && load_ok) begin
      full <= 1'b1;
      cnt  <= ROW_FIRST;
    end else if (take) begin
      cnt <= cnt + 2'd1;
      if (cnt == ROW_LAST) full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rows_valid && load_ok) hold <= rows_mat;
  end

  // row select; row 3 is the constant homogeneous row
  always_comb begin
    col0 = '0;
    col1 = '0;
    col2 = '0;
    col3 = FIX_ONE;
    if (cnt != ROW_LAST) begin
      col0 = DATA_W'($signed(hold.e[cnt][0]));
      col1 = DATA_W'($signed(hold.e[cnt][1]));
      col2 = DATA_W'($signed(hold.e[cnt][2]));
      col3 = hold.t[cnt];
    end
  end

  assign out_valid  = full;
  assign row_index  = cnt;
  assign degenerate = hold.degen;
  assign last       = (cnt == ROW_LAST);

endmodule

`default_nettype wire

FILE: rtl/lavm_checker.sv
// port-level checks on the row sequence of look_at_view_matrix
// uses lavm_pkg and look_at_view_matrix_macros.svh; bound to the top level
`default_nettype none
`include "look_at_view_matrix_macros.svh"

module lavm_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [1:0]                  row_index,
  input wire logic [lavm_pkg::DATA_W-1:0] col0,
  input wire logic [lavm_pkg::DATA_W-1:0] col1,
  input wire logic [lavm_pkg::DATA_W-1:0] col2,
  input wire logic [lavm_pkg::DATA_W-1:0] col3,
  input wire logic                        degenerate,
  input wire logic                        last
);
  import lavm_pkg::*;

  // stalled row keeps its row_index, col3 and degenerate
  `LAVM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(row_index) && $stable(col3) && $stable(degenerate))

  // rows of one matrix follow each other in order
  `LAVM_ASSERT_NEXT(a_row_seq, out_valid && out_ready && !last, out_valid && (row_index == 2'($past(row_index) + 2'd1)))

  // degenerate is the same on every row of a matrix
  `LAVM_ASSERT_NEXT(a_degen, out_valid && out_ready && !last, degenerate == $past(degenerate))

  // final row is the constant homogeneous row
  `LAVM_ASSERT_SAME(a_row3, out_valid && last, (row_index == ROW_LAST) && (col0 == '0) && (col1 == '0) && (col2 == '0) && (col3 == FIX_ONE))

  // a new matrix starts at row 0
  `LAVM_ASSERT_NEXT(a_first, out_valid && out_ready && last, !out_valid || (row_index == ROW_FIRST))

endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (.*);

`default_nettype wire
